@@ rtl/core/smws_pkg.sv @@
// Package: shared types and constants for the sparse merge work splitter.
`default_nettype none
package smws_pkg;
    localparam int unsigned MaxEntries = 1024;
    localparam int unsigned AddrW = $clog2(MaxEntries);
    localparam int unsigned CountW = AddrW + 1;
    localparam int unsigned IndexW = 32;
    localparam int unsigned RowW = 33;
    localparam int unsigned PosW = 48;
    localparam int unsigned FracW = 17;
    localparam int unsigned TotW = CountW + 1;
    localparam int unsigned TW = FracW + TotW;
    localparam int unsigned SmallWork = 1024;
    localparam logic [FracW-1:0] OneQ16 = 17'h10000;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0, OP_APPEND_A = 2'd1, OP_APPEND_B = 2'd2, OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        OUT_BALANCED = 2'd0, OUT_WHOLE = 2'd1, OUT_EMPTY = 2'd2, OUT_EXHAUSTED = 2'd3
    } t_outcome;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic app_a;
        logic app_b;
        logic load_q;      // capture query, set up row search
        logic set_whole;   // result: row 0 at both bases
        logic set_empty;   // result: row vector_length past both lists
        logic lb_start;    // start lower-bound pair for current probe
        logic lb_step;     // one lower-bound step: issue read or apply it
        logic row_update;  // apply too-low / too-high to row range
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic whole;
        logic empty;
        logic lb_done;
        logic fits;
        logic range_one;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/core/smws_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module smws_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/smws_datapath.sv @@
// Datapath: list stores, counts, row search range and lower-bound search.
`default_nettype none
module smws_datapath
    import smws_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [IndexW-1:0] i_row_index,
    input  wire logic [FracW-1:0]  i_frac,
    input  wire logic [PosW-1:0]   i_a_base,
    input  wire logic [PosW-1:0]   i_b_base,
    input  wire logic [RowW-1:0]   i_vector_length,
    output t_sts                   o_sts,
    output logic [RowW-1:0]        o_row_start,
    output logic [PosW-1:0]        o_a_position,
    output logic [PosW-1:0]        o_b_position
);
    logic [CountW-1:0] r_na, r_nb;
    logic [RowW-1:0]   r_low, r_high;
    logic [TW-1:0]     r_t;
    logic [PosW-1:0]   r_abase, r_bbase;
    logic [CountW-1:0] r_alo, r_ahi, r_blo, r_bhi;
    logic              r_rd_pend;
    logic              r_low_work, r_high_work, r_lb_done;
    logic [RowW-1:0]   w_probe;
    logic [RowW:0]     w_sum;
    logic [CountW-1:0] w_amid, w_bmid;
    logic [IndexW-1:0] w_adata, w_bdata;
    logic [AddrW-1:0]  w_aaddr, w_baddr;
    logic              w_awe, w_bwe;
    logic              w_lb_end, w_lb_last;
    logic [FracW-1:0]  w_frac;
    logic [TotW-1:0]   w_total;
    logic [TW-1:0]     w_t, w_all;
    logic [TotW-1:0]   w_work;
    logic [TW+3:0]     w_lhs5, w_lhs4, w_rhs4, w_rhs5;

    assign w_sum   = {1'b0, r_low} + {1'b0, r_high};
    assign w_probe = w_sum[RowW:1];
    assign w_amid  = r_alo + ((r_ahi - r_alo) >> 1);
    assign w_bmid  = r_blo + ((r_bhi - r_blo) >> 1);
    assign w_awe   = i_cmd.app_a && (r_na < CountW'(MaxEntries));
    assign w_bwe   = i_cmd.app_b && (r_nb < CountW'(MaxEntries));
    assign w_aaddr = w_awe ? r_na[AddrW-1:0] : w_amid[AddrW-1:0];
    assign w_baddr = w_bwe ? r_nb[AddrW-1:0] : w_bmid[AddrW-1:0];
    assign w_lb_end  = (r_alo >= r_ahi) && (r_blo >= r_bhi);
    assign w_lb_last = i_cmd.lb_step && !r_rd_pend && w_lb_end;

    smws_ram #(.Width(IndexW), .Depth(MaxEntries)) u_ram_a (
        .i_clk(i_clk), .i_we(w_awe), .i_addr(w_aaddr),
        .i_wdata(i_row_index), .o_rdata(w_adata));
    smws_ram #(.Width(IndexW), .Depth(MaxEntries)) u_ram_b (
        .i_clk(i_clk), .i_we(w_bwe), .i_addr(w_baddr),
        .i_wdata(i_row_index), .o_rdata(w_bdata));

    assign w_frac  = (i_frac > OneQ16) ? OneQ16 : i_frac;
    assign w_total = TotW'(r_na) + TotW'(r_nb);
    assign w_t     = TW'(w_frac) * TW'(w_total);
    assign w_all   = TW'({w_total, 16'b0});
    assign w_work  = TotW'(r_na - r_alo) + TotW'(r_nb - r_blo);
    assign w_lhs5  = (TW+4)'({w_work, 16'b0}) * (TW+4)'(5);
    assign w_lhs4  = (TW+4)'({w_work, 18'b0});
    assign w_rhs4  = (TW+4)'({r_t, 2'b0});
    assign w_rhs5  = (TW+4)'({r_t, 2'b0}) + (TW+4)'(r_t);

    assign o_sts.whole     = (w_all - r_t) < TW'(SmallWork * 65536);
    assign o_sts.empty     = r_t < TW'(SmallWork * 65536);
    assign o_sts.lb_done   = r_lb_done;
    assign o_sts.fits      = !r_low_work && !r_high_work;
    assign o_sts.range_one = (r_low == r_high);
    assign o_row_start     = w_probe;
    assign o_a_position    = r_abase + PosW'(r_alo);
    assign o_b_position    = r_bbase + PosW'(r_blo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_na <= '0;
            r_nb <= '0;
            r_low <= '0;
            r_high <= '0;
            r_alo <= '0;
            r_ahi <= '0;
            r_blo <= '0;
            r_bhi <= '0;
            r_rd_pend <= 1'b0;
            r_lb_done <= 1'b0;
        end else begin
            if (i_cmd.clear) r_na <= '0;
            else if (w_awe) r_na <= r_na + 1'b1;
            if (i_cmd.clear) r_nb <= '0;
            else if (w_bwe) r_nb <= r_nb + 1'b1;
            r_lb_done <= w_lb_last;
            r_rd_pend <= i_cmd.lb_step && !r_rd_pend && !w_lb_end;
            if (i_cmd.load_q) begin
                r_t <= w_t;
                r_abase <= i_a_base;
                r_bbase <= i_b_base;
                r_low <= '0;
                r_high <= (i_vector_length == '0) ? '0 : i_vector_length - 1'b1;
            end else if (i_cmd.set_whole) begin
                r_low <= '0;
                r_high <= '0;
            end else if (i_cmd.set_empty) begin
                r_low <= i_vector_length;
                r_high <= i_vector_length;
            end else if (i_cmd.row_update) begin
                if (r_low_work) r_high <= w_probe;
                else r_low <= w_probe + 1'b1;
            end
            if (i_cmd.clear || i_cmd.set_whole) begin
                r_alo <= '0;
                r_ahi <= '0;
                r_blo <= '0;
                r_bhi <= '0;
            end else if (i_cmd.set_empty) begin
                r_alo <= r_na;
                r_ahi <= r_na;
                r_blo <= r_nb;
                r_bhi <= r_nb;
            end else if (i_cmd.lb_start) begin
                r_alo <= '0;
                r_ahi <= r_na;
                r_blo <= '0;
                r_bhi <= r_nb;
            end else if (i_cmd.lb_step && r_rd_pend) begin
                if (r_alo < r_ahi) begin
                    if (RowW'(w_adata) < w_probe) r_alo <= w_amid + 1'b1;
                    else r_ahi <= w_amid;
                end
                if (r_blo < r_bhi) begin
                    if (RowW'(w_bdata) < w_probe) r_blo <= w_bmid + 1'b1;
                    else r_bhi <= w_bmid;
                end
            end
            if (w_lb_last) begin
                r_low_work <= w_lhs5 < w_rhs4;
                r_high_work <= w_lhs4 > w_rhs5;
            end
        end
    end

    // the probe never leaves the search range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_high |-> (w_probe >= r_low && w_probe <= r_high))
        else $error("probe outside range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alo <= r_ahi && r_ahi <= r_na) else $error("list A bound broken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blo <= r_bhi && r_bhi <= r_nb) else $error("list B bound broken");
endmodule
`default_nettype wire

@@ rtl/core/smws_ctrl.sv @@
// Controller: sequences list updates, query special cases and the row search.
`default_nettype none
module smws_ctrl
    import smws_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_fire,
    input  wire logic [1:0] i_op,
    input  wire logic       i_out_free,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_emit,
    output t_outcome        o_outcome
);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_LB, S_DECIDE, S_WAIT
    } t_state;
    t_state r_state;
    t_outcome r_outcome;

    always_comb begin
        o_cmd = '0;
        o_emit = 1'b0;
        o_outcome = r_outcome;
        if (i_in_fire) begin
            case (i_op)
                OP_CLEAR:    o_cmd.clear = 1'b1;
                OP_APPEND_A: o_cmd.app_a = 1'b1;
                OP_APPEND_B: o_cmd.app_b = 1'b1;
                default:     o_cmd.load_q = 1'b1;
            endcase
        end
        case (r_state)
            S_CHECK: begin
                if (i_sts.whole) o_outcome = OUT_WHOLE;
                else if (i_sts.empty) o_outcome = OUT_EMPTY;
                o_cmd.set_whole = i_sts.whole;
                o_cmd.set_empty = !i_sts.whole && i_sts.empty;
                o_cmd.lb_start = !(i_sts.whole || i_sts.empty);
            end
            S_LB: o_cmd.lb_step = !i_sts.lb_done;
            S_DECIDE: begin
                o_outcome = i_sts.fits ? OUT_BALANCED : OUT_EXHAUSTED;
                o_cmd.row_update = !(i_sts.fits || i_sts.range_one);
                o_cmd.lb_start = o_cmd.row_update;
            end
            S_WAIT: o_emit = i_out_free;
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_outcome <= OUT_BALANCED;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_fire && i_op == OP_QUERY) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_sts.whole || i_sts.empty) begin
                        r_outcome <= o_outcome;
                        r_state <= S_WAIT;
                    end else r_state <= S_LB;
                end
                S_LB: if (i_sts.lb_done) r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_sts.fits || i_sts.range_one) begin
                        r_outcome <= o_outcome;
                        r_state <= S_WAIT;
                    end else r_state <= S_LB;
                end
                S_WAIT: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> r_state == S_WAIT) else $error("emit outside wait");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |-> r_state == S_IDLE) else $error("accept while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.lb_step, o_cmd.load_q, o_cmd.row_update}))
        else $error("command clash");
endmodule
`default_nettype wire

@@ rtl/core/sparse_merge_work_splitter_top.sv @@
// Top level: sparse merge work splitter with stream ports.
//
// channel   dir  bits          contents
// s_axis    in   152 + user 2  row_index, fraction, a_base, b_base; user: operation
// m_axis    out  136 + user 2  row_start, a_position, b_position; user: outcome
// cfg       in    33           vector_length
//
// List ops are applied on acceptance. A query ends early for the special
// cases; otherwise it runs up to 34 probes, each a pass of the
// shared lower-bound loop on the two list RAMs (one read per step).
// Reset is synchronous; lists empty, vector_length 2^32.
// A held result stalls the next query only; the output register frees s_axis.
`default_nettype none
module sparse_merge_work_splitter_top
    import smws_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [151:0] s_axis_tdata,  // row_index, fraction, a_base, b_base
    input  wire logic [1:0]   s_axis_tuser,  // operation
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata,  // row_start, a_position, b_position
    output logic [1:0]        m_axis_tuser,  // outcome
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [32:0]  i_cfg_data     // vector_length
);
    t_cmd w_cmd;
    t_sts w_sts;
    t_outcome w_outcome;
    logic w_busy, w_emit, w_fire;
    logic [RowW-1:0] r_vlen, w_row;
    logic [PosW-1:0] w_apos, w_bpos;
    logic r_ovalid;
    logic [135:0] r_odata;
    logic [1:0] r_ouser;

    assign s_axis_tready = !w_busy;
    assign w_fire = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = !w_busy;

    smws_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_op(s_axis_tuser), .i_out_free(!r_ovalid || m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(w_busy), .o_emit(w_emit),
        .o_outcome(w_outcome));

    smws_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_row_index(s_axis_tdata[31:0]), .i_frac(s_axis_tdata[48:32]),
        .i_a_base(s_axis_tdata[96:49]), .i_b_base(s_axis_tdata[144:97]),
        .i_vector_length(r_vlen), .o_sts(w_sts), .o_row_start(w_row),
        .o_a_position(w_apos), .o_b_position(w_bpos));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= 33'h1_0000_0000;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_vlen <= i_cfg_data;
            if (w_emit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (w_emit) begin
                r_odata <= {7'b0, w_bpos, w_apos, w_row};
                r_ouser <= w_outcome;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;
endmodule
`default_nettype wire
